FILE: src/lbmd2q9_pkg.sv
// shared constants and types for the d2q9 bgk node update
// depends on nothing
package lbmd2q9_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 28;
  localparam int NDIR          = 9;
  localparam int RELAX_BITS    = 30;
  localparam logic [RELAX_BITS-1:0] RELAX_RESET = 30'd479349029;

  // direction order: rest, e, n, w, s, ne, nw, sw, se
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int WCLASS [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic {
    REG_RELAX_RATE = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: src/lbmd2q9_front.sv
// front stage: takes one node item, sums density and momentum, flags faults
// depends on lbmd2q9_pkg
module lbmd2q9_front #(
  parameter int WORD_BITS = lbmd2q9_pkg::WORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic [lbmd2q9_pkg::NDIR-1:0][WORD_BITS-1:0] dist_i,
  input  lbmd2q9_pkg::q_status_t                    qstat_i,
  output logic                                      stall_o,
  output logic                                      push_o,
  output logic [12*WORD_BITS:0]                     item_o
);

  localparam int EW = WORD_BITS + 4;
  localparam logic signed [EW-1:0] MAXV = EW'((65'd1 << (WORD_BITS - 1)) - 65'd1);
  localparam logic signed [EW-1:0] MINV = -MAXV - EW'(1);

  function automatic logic [WORD_BITS-1:0] sat_w(input logic signed [EW-1:0] x);
    if (x > MAXV) return MAXV[WORD_BITS-1:0];
    if (x < MINV) return MINV[WORD_BITS-1:0];
    return x[WORD_BITS-1:0];
  endfunction

  logic signed [EW-1:0] rho, jx, jy;
  logic                 adv, accept;

  logic                 fv_q, flt_q;
  logic [WORD_BITS-1:0] den_q, jx_q, jy_q;
  logic [lbmd2q9_pkg::NDIR-1:0][WORD_BITS-1:0] f_q;

  always_comb begin
    logic signed [EW-1:0] v;
    rho = '0;
    jx  = '0;
    jy  = '0;
    for (int i = 0; i < lbmd2q9_pkg::NDIR; i++) begin
      v   = EW'($signed(dist_i[i]));
      rho = rho + v;
      if (lbmd2q9_pkg::DIR_X[i] > 0) jx = jx + v;
      else if (lbmd2q9_pkg::DIR_X[i] < 0) jx = jx - v;
      if (lbmd2q9_pkg::DIR_Y[i] > 0) jy = jy + v;
      else if (lbmd2q9_pkg::DIR_Y[i] < 0) jy = jy - v;
    end
  end

  assign adv     = !fv_q || !qstat_i.full;
  assign stall_o = !adv;
  assign accept  = valid_i && adv;
  assign push_o  = fv_q && !qstat_i.full;
  assign item_o  = {flt_q, jy_q, jx_q, den_q, f_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (adv) begin
      fv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q   <= dist_i;
      den_q <= sat_w(rho);
      jx_q  <= sat_w(jx);
      jy_q  <= sat_w(jy);
      flt_q <= rho[EW-1] || (rho == '0);
    end
  end

endmodule

FILE: src/lbmd2q9_queue.sv
// short fifo between the front stage and the collision pipeline
// depends on lbmd2q9_pkg
module lbmd2q9_queue #(
  parameter int DW = 12 * lbmd2q9_pkg::WORD_BITS_DEF + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [DW-1:0]           data_i,
  input  logic                    pop_i,
  output logic [DW-1:0]           head_o,
  output lbmd2q9_pkg::q_status_t  status_o
);

  logic [DW-1:0] data_q [lbmd2q9_pkg::QUEUE_DEPTH];
  logic [lbmd2q9_pkg::QPTR_BITS-1:0] wr_q, rd_q;
  logic [lbmd2q9_pkg::QCNT_BITS-1:0] cnt_q;

  assign head_o         = data_q[rd_q];
  assign status_o.full  = (cnt_q == lbmd2q9_pkg::QCNT_BITS'(lbmd2q9_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) data_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

FILE: src/lbmd2q9_div.sv
// pipelined restoring divider, one quotient bit per stage
// computes (num << FRAC_BITS) / den truncated and saturated; depends on nothing
module lbmd2q9_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [WORD_BITS-1:0] num_i,
  input  logic [WORD_BITS-1:0]        den_i,
  output logic signed [WORD_BITS-1:0] quo_o
);

  localparam int W  = WORD_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS;
  localparam int CW = NW + WORD_BITS;
  localparam logic signed [W-1:0] MAXV = W'((65'd1 << (W - 1)) - 65'd1);
  localparam logic signed [W-1:0] MINV = -MAXV - W'(1);

  logic [NW-1:0] rem_q [W];
  logic [NW-1:0] rem_d [W];
  logic [W-2:0]  qb_q  [W];
  logic [W-2:0]  qb_d  [W];
  logic [W-1:0]  den_q [W];
  logic          neg_q [W];
  logic          ovf_q [W];
  logic signed [W-1:0] quo_q;
  logic [W-1:0]  mag;

  always_comb begin
    logic [CW-1:0] t;
    mag      = num_i[W-1] ? (~num_i + 1'b1) : num_i;
    rem_d[0] = {mag, {FRAC_BITS{1'b0}}};
    qb_d[0]  = '0;
    for (int k = 1; k < W; k++) begin
      t        = CW'(den_q[k-1]) << (W - 1 - k);
      rem_d[k] = rem_q[k-1];
      qb_d[k]  = qb_q[k-1];
      if (CW'(rem_q[k-1]) >= t) begin
        rem_d[k] = NW'(CW'(rem_q[k-1]) - t);
        qb_d[k][W-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      qb_q[0]  <= qb_d[0];
      den_q[0] <= den_i;
      neg_q[0] <= num_i[W-1];
      ovf_q[0] <= CW'(rem_d[0]) >= (CW'(den_i) << (W - 1));
      for (int k = 1; k < W; k++) begin
        rem_q[k] <= rem_d[k];
        qb_q[k]  <= qb_d[k];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      if (ovf_q[W-1]) quo_q <= neg_q[W-1] ? MINV : MAXV;
      else if (neg_q[W-1]) quo_q <= -$signed({1'b0, qb_q[W-1]});
      else quo_q <= $signed({1'b0, qb_q[W-1]});
    end
  end

  assign quo_o = quo_q;

endmodule

FILE: src/lbmd2q9_back.sv
// collision pipeline: velocity, equilibrium, relaxation and output register
// depends on lbmd2q9_pkg and lbmd2q9_div
module lbmd2q9_back #(
  parameter int WORD_BITS = lbmd2q9_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lbmd2q9_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [12*WORD_BITS:0]                 head_i,
  input  lbmd2q9_pkg::q_status_t                qstat_i,
  input  logic [lbmd2q9_pkg::RELAX_BITS-1:0]    relax_i,
  input  logic                                  stall_i,
  output logic                                  pop_o,
  output logic                                  valid_o,
  output logic [lbmd2q9_pkg::NDIR-1:0][WORD_BITS-1:0] post_o,
  output logic [WORD_BITS-1:0]                  dens_o,
  output logic                                  fault_o
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int ND  = lbmd2q9_pkg::NDIR;
  localparam int RB  = lbmd2q9_pkg::RELAX_BITS;
  localparam int XW  = 2 * W + RB + 4;
  localparam int PW  = W + RB + 2;
  localparam int LEN = W + 7;

  localparam logic [63:0] MAXU = (64'd1 << (W - 1)) - 64'd1;
  localparam logic signed [XW-1:0] MAXX = XW'(MAXU);
  localparam logic signed [XW-1:0] MINX = -MAXX - XW'(1);
  localparam logic signed [XW-1:0] HALF = XW'(64'd1 << (F - 1));

  localparam logic [63:0] ONE_R = 64'd1 << F;
  localparam logic [63:0] W0_R  = ((64'd8 << F) + 64'd9) / 64'd18;
  localparam logic [63:0] W1_R  = ((64'd2 << F) + 64'd9) / 64'd18;
  localparam logic [63:0] W2_R  = ((64'd2 << F) + 64'd36) / 64'd72;
  localparam logic [63:0] C45_R = ((64'd18 << F) + 64'd2) / 64'd4;
  localparam logic [63:0] C15_R = ((64'd6 << F) + 64'd2) / 64'd4;
  localparam logic signed [W-1:0] ONE = W'((ONE_R > MAXU) ? MAXU : ONE_R);
  localparam logic signed [W-1:0] WT0 = W'((W0_R > MAXU) ? MAXU : W0_R);
  localparam logic signed [W-1:0] WT1 = W'((W1_R > MAXU) ? MAXU : W1_R);
  localparam logic signed [W-1:0] WT2 = W'((W2_R > MAXU) ? MAXU : W2_R);
  localparam logic signed [W-1:0] C45 = W'((C45_R > MAXU) ? MAXU : C45_R);
  localparam logic signed [W-1:0] C15 = W'((C15_R > MAXU) ? MAXU : C15_R);

  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] x);
    if (x > MAXX) return MAXX[W-1:0];
    if (x < MINX) return MINX[W-1:0];
    return x[W-1:0];
  endfunction

  // product, round half up, saturate
  function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] m;
    logic signed [XW-1:0]  p;
    m = (2*W)'(a) * (2*W)'(b);
    p = (XW'(m) + HALF) >>> F;
    return sat_x(p);
  endfunction

  logic en;
  logic signed [W-1:0] hd_den, hd_jx, hd_jy, ux, uy;
  logic [ND-1:0][W-1:0] hd_f;
  logic hd_flt;

  assign {hd_flt, hd_jy, hd_jx, hd_den, hd_f} = head_i;
  assign en    = !valid_o || !stall_i;
  assign pop_o = en && !qstat_i.empty;

  lbmd2q9_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_x (
    .clk_i(clk_i), .en_i(en), .num_i(hd_jx), .den_i(hd_den), .quo_o(ux)
  );

  lbmd2q9_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div_y (
    .clk_i(clk_i), .en_i(en), .num_i(hd_jy), .den_i(hd_den), .quo_o(uy)
  );

  // item carry line, aligned with the arithmetic stages
  logic                 cv_q   [LEN];
  logic [ND-1:0][W-1:0] cf_q   [LEN];
  logic signed [W-1:0]  cd_q   [LEN];
  logic                 cflt_q [LEN];

  // arithmetic stage registers
  logic signed [W-1:0] ux2_q, uy2_q, usq_q, usqt_q;
  logic signed [W-1:0] cu1_q [ND], cu2_q [ND], cu3_q [ND];
  logic signed [W-1:0] sq_q [ND], c45t_q [ND], poly_q [ND], feq_q [ND];
  logic signed [W-1:0] rw1_q [3], rw2_q [3], rw3_q [3], rw4_q [3];
  logic signed [PW-1:0] prod_q [ND];

  logic signed [W-1:0] rw_d [3];

  assign rw_d[0] = WT0;
  assign rw_d[1] = WT1;
  assign rw_d[2] = WT2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LEN; s++) cv_q[s] <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      cv_q[0] <= pop_o;
      for (int s = 1; s < LEN; s++) cv_q[s] <= cv_q[s-1];
      valid_o <= cv_q[LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [XW-1:0] acc;
    logic signed [W:0]    dif;
    if (en) begin
      cf_q[0]   <= hd_f;
      cd_q[0]   <= hd_den;
      cflt_q[0] <= hd_flt;
      for (int s = 1; s < LEN; s++) begin
        cf_q[s]   <= cf_q[s-1];
        cd_q[s]   <= cd_q[s-1];
        cflt_q[s] <= cflt_q[s-1];
      end

      // velocity squares, projections, weighted density
      ux2_q <= mulq(ux, ux);
      uy2_q <= mulq(uy, uy);
      for (int i = 0; i < ND; i++) begin
        acc = '0;
        if (lbmd2q9_pkg::DIR_X[i] > 0) acc = acc + XW'(ux);
        else if (lbmd2q9_pkg::DIR_X[i] < 0) acc = acc - XW'(ux);
        if (lbmd2q9_pkg::DIR_Y[i] > 0) acc = acc + XW'(uy);
        else if (lbmd2q9_pkg::DIR_Y[i] < 0) acc = acc - XW'(uy);
        cu1_q[i] <= sat_x(acc);
      end
      for (int k = 0; k < 3; k++) rw1_q[k] <= mulq(cd_q[W], rw_d[k]);

      // u^2 and cu^2
      usq_q <= sat_x(XW'(ux2_q) + XW'(uy2_q));
      for (int i = 0; i < ND; i++) begin
        sq_q[i]  <= mulq(cu1_q[i], cu1_q[i]);
        cu2_q[i] <= cu1_q[i];
      end
      rw2_q <= rw1_q;

      // scaled terms
      usqt_q <= mulq(usq_q, C15);
      for (int i = 0; i < ND; i++) begin
        c45t_q[i] <= mulq(sq_q[i], C45);
        cu3_q[i]  <= cu2_q[i];
      end
      rw3_q <= rw2_q;

      // polynomial
      for (int i = 0; i < ND; i++) begin
        acc = XW'(ONE) + XW'(cu3_q[i]) + XW'(cu3_q[i]) + XW'(cu3_q[i])
            + XW'(c45t_q[i]) - XW'(usqt_q);
        poly_q[i] <= sat_x(acc);
      end
      rw4_q <= rw3_q;

      // equilibrium
      for (int i = 0; i < ND; i++)
        feq_q[i] <= mulq(rw4_q[lbmd2q9_pkg::WCLASS[i]], poly_q[i]);

      // exact relaxation product r * (feq - f)
      for (int i = 0; i < ND; i++) begin
        dif = (W+1)'(feq_q[i]) - (W+1)'($signed(cf_q[W+5][i]));
        prod_q[i] <= PW'(dif) * PW'($signed({1'b0, relax_i}));
      end

      // output register: round once, add f, saturate; faults pass through
      for (int i = 0; i < ND; i++) begin
        acc = ((XW'(prod_q[i]) + HALF) >>> F) + XW'($signed(cf_q[W+6][i]));
        post_o[i] <= cflt_q[W+6] ? cf_q[W+6][i] : sat_x(acc);
      end
      dens_o  <= cd_q[W+6];
      fault_o <= cflt_q[W+6];
    end
  end

endmodule

FILE: src/lbm_d2q9_bgk_node_update.sv
// top level of the d2q9 bgk node update
// depends on lbmd2q9_pkg, lbmd2q9_front, lbmd2q9_queue, lbmd2q9_back
//
// usage:
// - input channel valid_i / stall_o carries one lattice node item: the nine
//   streamed distributions in standard d2q9 order, signed fixed point
// - output channel valid_o / stall_i carries the nine post-collision values,
//   the node density and the density fault flag
// - an item is taken at a clock edge with valid high and stall low
// - throughput is one item per cycle while no stall holds the flow; the latency
//   from acceptance to valid_o is set by the two pipelined dividers that give
//   one quotient bit per stage
// - a four-entry queue parts the front stage from the collision pipeline;
//   while stall_i is high the pipeline holds and the queue fills, and
//   stall_o rises only once the queue is full
// - the relaxation rate sits behind an apb write port at byte address 0;
//   write it only while the block is empty
// - reset clears all valid state and loads the default relaxation rate
// - when the density sum is zero or negative the inputs pass through,
//   density_fault_o is set and node_density_o still gives the sum
module lbm_d2q9_bgk_node_update #(
  parameter int WORD_BITS = lbmd2q9_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = lbmd2q9_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // config port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lbmd2q9_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lbmd2q9_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lbmd2q9_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                    pready,
  // input item
  input  logic                                    valid_i,
  output logic                                    stall_o,
  input  logic signed [WORD_BITS-1:0]             dist_rest_i,
  input  logic signed [WORD_BITS-1:0]             dist_east_i,
  input  logic signed [WORD_BITS-1:0]             dist_north_i,
  input  logic signed [WORD_BITS-1:0]             dist_west_i,
  input  logic signed [WORD_BITS-1:0]             dist_south_i,
  input  logic signed [WORD_BITS-1:0]             dist_northeast_i,
  input  logic signed [WORD_BITS-1:0]             dist_northwest_i,
  input  logic signed [WORD_BITS-1:0]             dist_southwest_i,
  input  logic signed [WORD_BITS-1:0]             dist_southeast_i,
  // result item
  output logic                                    valid_o,
  input  logic                                    stall_i,
  output logic signed [WORD_BITS-1:0]             post_rest_o,
  output logic signed [WORD_BITS-1:0]             post_east_o,
  output logic signed [WORD_BITS-1:0]             post_north_o,
  output logic signed [WORD_BITS-1:0]             post_west_o,
  output logic signed [WORD_BITS-1:0]             post_south_o,
  output logic signed [WORD_BITS-1:0]             post_northeast_o,
  output logic signed [WORD_BITS-1:0]             post_northwest_o,
  output logic signed [WORD_BITS-1:0]             post_southwest_o,
  output logic signed [WORD_BITS-1:0]             post_southeast_o,
  output logic signed [WORD_BITS-1:0]             node_density_o,
  output logic                                    density_fault_o
);

  localparam int ND = lbmd2q9_pkg::NDIR;
  localparam int DW = 12 * WORD_BITS + 1;

  logic [lbmd2q9_pkg::RELAX_BITS-1:0] relax_q;
  lbmd2q9_pkg::reg_idx_e              reg_idx;
  logic                               cfg_wr;

  logic [ND-1:0][WORD_BITS-1:0] dist_vec, post;
  logic [DW-1:0]                push_data, head;
  logic                         push, pop;
  lbmd2q9_pkg::q_status_t       qstat;
  logic [WORD_BITS-1:0]         dens;

  // config register, one word at byte address 0
  assign pready  = 1'b1;
  assign reg_idx = lbmd2q9_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      lbmd2q9_pkg::REG_RELAX_RATE:
        prdata = lbmd2q9_pkg::APB_DATA_BITS'(relax_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= lbmd2q9_pkg::RELAX_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        lbmd2q9_pkg::REG_RELAX_RATE: relax_q <= pwdata[lbmd2q9_pkg::RELAX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // distributions in direction order
  assign dist_vec = {dist_southeast_i, dist_southwest_i, dist_northwest_i,
                     dist_northeast_i, dist_south_i, dist_west_i, dist_north_i,
                     dist_east_i, dist_rest_i};

  lbmd2q9_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .dist_i  (dist_vec),
    .qstat_i (qstat),
    .stall_o (stall_o),
    .push_o  (push),
    .item_o  (push_data)
  );

  lbmd2q9_queue #(.DW(DW)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (qstat)
  );

  lbmd2q9_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .relax_i (relax_q),
    .stall_i (stall_i),
    .pop_o   (pop),
    .valid_o (valid_o),
    .post_o  (post),
    .dens_o  (dens),
    .fault_o (density_fault_o)
  );

  assign post_rest_o      = post[0];
  assign post_east_o      = post[1];
  assign post_north_o     = post[2];
  assign post_west_o      = post[3];
  assign post_south_o     = post[4];
  assign post_northeast_o = post[5];
  assign post_northwest_o = post[6];
  assign post_southwest_o = post[7];
  assign post_southeast_o = post[8];
  assign node_density_o   = dens;

endmodule
